// ----- sv/podt_pkg.sv -----
// Shared types, codes and constants of the deadline timer.
`default_nettype none
package podt_pkg;
	localparam int TIME_WIDTH_DEF = 64;
	localparam int IVL_W = 48;
	localparam int GAP_W = 30;

	localparam logic [IVL_W-1:0] MIN_PERIOD_NS = IVL_W'(100 * 1000 * 1000);
	localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(1);

	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_START  = 2'd1;
	localparam logic [1:0] FUNC_STOP   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_ACTIVE    = 2'd2;
	localparam logic [1:0] ST_SUSPENDED = 2'd3;

	localparam logic CFG_INTERVAL = 1'b0;
	localparam logic CFG_GAP      = 1'b1;

	typedef struct packed {
		logic [1:0]       func;
		logic [63:0]      now_ns;
		logic [IVL_W-1:0] first_delay_ns;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [63:0] tick_number;
		logic        is_running;
		logic [63:0] next_deadline;
	} rsp_t;

	typedef struct packed {
		logic [IVL_W-1:0] interval_ns;
		logic [GAP_W-1:0] catchup_gap_ns;
	} cfg_t;
endpackage
`default_nettype wire

// ----- sv/podt_core.sv -----
// Timer state and the combinational command evaluation.
`default_nettype none
module podt_core import podt_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire cmd_t cmd,
	input  wire cfg_t cfg,
	output rsp_t      rsp
);
	logic                  running_q;
	logic [TIME_WIDTH-1:0] deadline_q;
	// start time plus the elapsed periods, kept as one running sum
	logic [TIME_WIDTH-1:0] periodic_q;
	logic [63:0]           tick_q;

	logic                  running_d;
	logic [TIME_WIDTH-1:0] deadline_d, periodic_d;
	logic [63:0]           tick_d;

	logic [TIME_WIDTH-1:0] now, start_at, next_per, catchup;
	logic                  first_bad, ivl_bad;

	assign now       = cmd.now_ns[TIME_WIDTH-1:0];
	assign start_at  = now + TIME_WIDTH'(cmd.first_delay_ns);
	assign next_per  = periodic_q + TIME_WIDTH'(cfg.interval_ns);
	assign catchup   = now + TIME_WIDTH'(cfg.catchup_gap_ns);
	assign first_bad = (cmd.first_delay_ns != '0) && (cmd.first_delay_ns < MIN_PERIOD_NS);
	assign ivl_bad   = (cfg.interval_ns != '0) && (cfg.interval_ns < MIN_PERIOD_NS);

	always_comb begin
		running_d       = running_q;
		deadline_d      = deadline_q;
		periodic_d      = periodic_q;
		tick_d          = tick_q;
		rsp.status      = ST_OK;
		rsp.fired       = 1'b0;
		rsp.tick_number = '0;
		unique case (cmd.func)
			FUNC_START: begin
				if (first_bad || ivl_bad) begin
					rsp.status = ST_INVALID;
				end else if (running_q) begin
					rsp.status = ST_ACTIVE;
				end else begin
					running_d  = 1'b1;
					deadline_d = start_at;
					periodic_d = start_at;
					tick_d     = '0;
				end
			end
			FUNC_STOP: begin
				if (!running_q) begin
					rsp.status = ST_SUSPENDED;
				end else begin
					running_d = 1'b0;
				end
			end
			FUNC_SAMPLE: begin
				if (running_q && now >= deadline_q) begin
					tick_d          = tick_q + 64'd1;
					rsp.fired       = 1'b1;
					rsp.tick_number = tick_q + 64'd1;
					if (cfg.interval_ns == '0) begin
						running_d = 1'b0;
					end else begin
						periodic_d = next_per;
						// deadline already behind us: push out by the gap
						deadline_d = (next_per < now) ? catchup : next_per;
					end
				end
			end
			default: ;
		endcase
		rsp.is_running    = running_d;
		rsp.next_deadline = running_d ? 64'(deadline_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			deadline_q <= '0;
			periodic_q <= '0;
			tick_q     <= '0;
		end else if (step) begin
			running_q  <= running_d;
			deadline_q <= deadline_d;
			periodic_q <= periodic_d;
			tick_q     <= tick_d;
		end
	end
endmodule
`default_nettype wire

// ----- sv/periodic_oneshot_deadline_timer.sv -----
// Top level: command register, config registers, timer core and result register.
// Items pass the command stage, then the result register rsp.
// Throughput: one item per cycle unless stalled; the state updates in one pass
// through the core (one compare and one add of TIME_WIDTH bits between registers).
// Reset: arst_n clears the timer to suspended, tick count 0, interval 0,
// catch-up gap 1; both pipeline valids drop at once.
`default_nettype none
module periodic_oneshot_deadline_timer import podt_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire cmd_t              cmd,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp,
	input  wire logic              cfg_we,
	input  wire logic              cfg_idx,
	input  wire logic [IVL_W-1:0]  cfg_data
);
	cfg_t cfg_q;

	// command stage
	logic valid_s1;
	cmd_t cmd_s1;
	logic move;
	rsp_t rsp_d;

	// the result register frees up when empty or when its item is taken
	assign move      = valid_s1 && (!rsp_valid || !rsp_stall);
	assign cmd_stall = valid_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ns    <= '0;
			cfg_q.catchup_gap_ns <= GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_INTERVAL: cfg_q.interval_ns    <= cfg_data;
				CFG_GAP:      cfg_q.catchup_gap_ns <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	podt_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (move),
		.cmd   (cmd_s1),
		.cfg   (cfg_q),
		.rsp   (rsp_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (!rsp_valid || !rsp_stall) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			rsp <= rsp_d;
		end
	end

	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fired |-> rsp.status == ST_OK)
		else $error("fired item carries an error status");

	a_idle_deadline: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.is_running |-> rsp.next_deadline == '0)
		else $error("deadline shown while suspended");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move |=> valid_s1 && $stable(cmd_s1))
		else $error("command stage lost a stalled item");

	a_move_fills: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> rsp_valid)
		else $error("result register did not take the item");
endmodule
`default_nettype wire

// ----- sim/periodic_oneshot_deadline_timer_test.sv -----
// Self-checking testbench for the periodic / one-shot deadline timer.
module periodic_oneshot_deadline_timer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import podt_pkg::*;

	// func value 3 has no name in the package; the block treats it as a no-op
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 850;
	localparam int CYCLE_LIMIT = 300_000;
	localparam int HOLD_CYCLES = 40;

	// Tracks the timer as the block should see it and keeps the replies still owed.
	// Every accepted item owes exactly one reply, in order.
	class deadline_scoreboard;
		logic [IVL_W-1:0] period;
		logic [GAP_W-1:0] catchup;
		logic             armed;
		logic [63:0]      origin;
		logic [63:0]      due;
		logic [63:0]      ticks;
		logic [63:0]      period_sum;
		rsp_t             awaited_replies[$];
		int               errors;

		function new();
			period = '0;
			catchup = GAP_RESET;
			armed = 1'b0;
			origin = '0;
			due = '0;
			ticks = '0;
			period_sum = '0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [IVL_W-1:0] value);
			if (idx == CFG_INTERVAL) begin
				period = value;
			end else begin
				catchup = value[GAP_W-1:0];
			end
		endfunction

		// nonzero periods under 100 ms are refused
		function logic period_bad(logic [IVL_W-1:0] v);
			return v != '0 && v < MIN_PERIOD_NS;
		endfunction

		function void note_command(cmd_t c);
			rsp_t r;
			r = '0;
			case (c.func)
				FUNC_START: begin
					// parameter check wins over the already-active check
					if (period_bad(c.first_delay_ns) || period_bad(period)) begin
						r.status = ST_INVALID;
					end else if (armed) begin
						r.status = ST_ACTIVE;
					end else begin
						origin = c.now_ns + 64'(c.first_delay_ns);
						due = origin;
						ticks = '0;
						period_sum = '0;
						armed = 1'b1;
					end
				end
				FUNC_STOP: begin
					if (!armed) begin
						r.status = ST_SUSPENDED;
					end else begin
						armed = 1'b0;
					end
				end
				FUNC_SAMPLE: begin
					if (armed && c.now_ns >= due) begin
						ticks = ticks + 64'd1;
						r.fired = 1'b1;
						r.tick_number = ticks;
						if (period == '0) begin
							armed = 1'b0;
						end else begin
							// drift-free: origin plus the running sum of periods
							period_sum = period_sum + 64'(period);
							due = origin + period_sum;
							if (due < c.now_ns)
								due = c.now_ns + 64'(catchup);
						end
					end
				end
				default: ;
			endcase
			r.is_running = armed;
			r.next_deadline = armed ? due : '0;
			awaited_replies.push_back(r);
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t want;
			if (awaited_replies.size() == 0) begin
				$error("reply with no item awaiting it");
				errors++;
				return;
			end
			want = awaited_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.fired !== want.fired) begin
				$error("fired: expected %0d, got %0d", want.fired, got.fired);
				errors++;
			end
			if (got.tick_number !== want.tick_number) begin
				$error("tick_number: expected %0d, got %0d", want.tick_number, got.tick_number);
				errors++;
			end
			if (got.is_running !== want.is_running) begin
				$error("is_running: expected %0d, got %0d", want.is_running, got.is_running);
				errors++;
			end
			if (got.next_deadline !== want.next_deadline) begin
				$error("next_deadline: expected %0h, got %0h",
					want.next_deadline, got.next_deadline);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	cmd_t             cmd = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_we = 1'b0;
	logic             cfg_idx = CFG_INTERVAL;
	logic [IVL_W-1:0] cfg_data = '0;

	deadline_scoreboard board;
	int               items_sent = 0;
	int               cycle_count = 0;
	logic             steady = 1'b0;   // when set neither side idles
	logic             hold_req = 1'b0; // asks the receiver for one long stall
	logic [63:0]      wall_ns = '0;    // notional time of the stimulus

	periodic_oneshot_deadline_timer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a run still going at CYCLE_LIMIT is reported as failed.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one item, with a random idle gap before it, and hold it until taken.
	// valid is left high after acceptance; the next call either reuses it
	// straight away or lowers it, so it never sees two updates in one step.
	task automatic send(logic [1:0] func, logic [63:0] now, logic [IVL_W-1:0] first);
		int   gap;
		cmd_t c;
		gap = steady ? 0 : $urandom_range(0, 6);
		c.func = func;
		c.now_ns = now;
		c.first_delay_ns = first;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		board.note_command(c);
		if (func != FUNC_UNUSED)
			items_sent++;
	endtask

	// Stop offering, wait for every owed reply, then allow the pipeline to empty.
	task automatic drain_timer();
		cmd_valid <= 1'b0;
		while (board.awaited_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers on consecutive edges; only called with the block idle.
	task automatic load_settings(logic [IVL_W-1:0] period, logic [IVL_W-1:0] gap_word);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_INTERVAL;
		cfg_data <= period;
		@(posedge clk);
		board.set_reg(CFG_INTERVAL, period);
		cfg_idx <= CFG_GAP;
		cfg_data <= gap_word;
		@(posedge clk);
		board.set_reg(CFG_GAP, gap_word);
		cfg_we <= 1'b0;
	endtask

	// Time advance between samples, scaled to the period so deadlines are
	// hit often; overshoots exercise catch-up, rare negative steps go backwards.
	function automatic logic [63:0] pick_step(logic [IVL_W-1:0] period);
		logic [63:0] span;
		logic [63:0] noise;
		int          pick;
		span = (period == '0) ? 64'(MIN_PERIOD_NS) : 64'(period);
		noise = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return noise % (span / 3 + 1);
		else if (pick < 80)
			return span;
		else if (pick < 92)
			return span * 3 + noise % span;
		else if (pick < 96)
			return '0;
		else
			return -(noise % span);
	endfunction

	function automatic logic [IVL_W-1:0] pick_delay();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return '0;
		else if (pick < 30)
			return MIN_PERIOD_NS;
		else if (pick < 36)
			return MIN_PERIOD_NS - 1'b1;
		else if (pick < 85)
			return IVL_W'($urandom_range(100_000_000, 2_000_000_000));
		else
			return IVL_W'({$urandom, $urandom});
	endfunction

	function automatic logic [IVL_W-1:0] pick_period();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return '0;
		else if (pick < 25)
			return MIN_PERIOD_NS;
		else if (pick < 33)
			return IVL_W'($urandom_range(1, 99_999_999));
		else if (pick < 88)
			return IVL_W'($urandom_range(100_000_000, 1_000_000_000));
		else if (pick < 95)
			return IVL_W'({$urandom, $urandom});
		else
			return '1;
	endfunction

	// Upper bits of the write word are random: only the low 30 bits belong to the gap.
	function automatic logic [IVL_W-1:0] pick_gap_word();
		logic [GAP_W-1:0] gap;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			gap = '0;
		else if (pick < 15)
			gap = '1;
		else if (pick < 35)
			gap = GAP_W'($urandom_range(1, 1000));
		else
			gap = GAP_W'($urandom_range(1, 1_000_000_000));
		return {(IVL_W-GAP_W)'($urandom), gap};
	endfunction

	// Mostly well-formed traffic: starts, stops and time samples that walk
	// through the deadlines; a few fully random items as noise.
	task automatic run_episode(int length);
		int               pick;
		logic [1:0]       func;
		logic [63:0]      now;
		logic [IVL_W-1:0] first;
		repeat (length) begin
			pick = $urandom_range(0, 99);
			first = IVL_W'({$urandom, $urandom});
			now = wall_ns;
			if (pick < 5) begin
				func = 2'($urandom);
				now = {$urandom, $urandom};
			end else if (pick < 13) begin
				func = FUNC_START;
				first = pick_delay();
			end else if (pick < 17) begin
				func = FUNC_STOP;
			end else if (pick < 19) begin
				func = FUNC_UNUSED;
			end else begin
				func = FUNC_SAMPLE;
				pick = $urandom_range(0, 9);
				// land exactly on, or just short of, the pending deadline
				if (pick == 0) begin
					now = board.due;
				end else if (pick == 1) begin
					now = board.due - 64'd1;
				end else begin
					wall_ns = wall_ns + pick_step(board.period);
					now = wall_ns;
				end
			end
			send(func, now, first);
		end
	endtask

	// Receiver: random stall before each reply, sometimes none at all, and
	// one long hold on request so the block backs up into its input.
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				hold = steady ? 0 : $urandom_range(0, 6);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			board.check_rsp(rsp);
		end
	end

	initial begin
		int episode;
		int pick;
		episode = 0;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one-shot, catch-up gap 1.
		send(FUNC_STOP, 64'd0, '0);                      // stop while suspended
		send(FUNC_SAMPLE, 64'd500, '0);                  // sample while suspended
		send(FUNC_UNUSED, '1, '1);                       // unused func code
		send(FUNC_START, 64'd1000, '0);                  // zero delay: due at once
		send(FUNC_START, 64'd1000, MIN_PERIOD_NS);       // already active
		send(FUNC_START, 64'd1000, MIN_PERIOD_NS - 1'b1); // bad delay beats active
		send(FUNC_SAMPLE, 64'd999, '0);                  // one short of the deadline
		send(FUNC_SAMPLE, 64'd1000, '0);                 // fires, one-shot suspends
		send(FUNC_START, 64'd0, MIN_PERIOD_NS);          // shortest legal delay
		send(FUNC_STOP, 64'd5, '0);
		send(FUNC_STOP, 64'd6, '0);
		send(FUNC_START, '1, '1);                        // deadline wraps past 2^64
		send(FUNC_SAMPLE, '1, '0);

		// Shortest period, zero catch-up gap: a late timer refires on the next sample.
		drain_timer();
		load_settings(MIN_PERIOD_NS, '0);
		send(FUNC_START, 64'd0, '0);
		send(FUNC_SAMPLE, 64'd0, '0);
		send(FUNC_START, 64'd7, '0);
		send(FUNC_SAMPLE, 64'd350_000_000, '0);
		send(FUNC_SAMPLE, 64'd350_000_000, '0);
		send(FUNC_SAMPLE, 64'd400_000_000, '0);
		send(FUNC_STOP, 64'd400_000_000, '0);

		// Period one short of the minimum: every start refused.
		drain_timer();
		load_settings(MIN_PERIOD_NS - 1'b1, '1);
		send(FUNC_START, 64'd0, '0);

		// Largest period and gap near the top of time: both sums wrap.
		drain_timer();
		load_settings('1, '1);
		send(FUNC_START, '1 - 64'd9, '0);
		send(FUNC_SAMPLE, '1 - 64'd9, '0);
		send(FUNC_SAMPLE, '1, '0);
		send(FUNC_STOP, '1, '0);

		// Random episodes: the timer may be left armed across a settings change,
		// so a new period or gap applies to a running timer too.
		while (items_sent < ITEM_TARGET) begin
			drain_timer();
			load_settings(pick_period(), pick_gap_word());
			pick = $urandom_range(0, 99);
			if (pick < 40)
				wall_ns = {$urandom, $urandom};
			else if (pick < 55)
				wall_ns = '1 - 64'($urandom);
			else if (pick < 70)
				wall_ns = 64'($urandom);
			if (episode == 2) begin
				// receiver holds off while items keep coming back to back
				steady = 1'b1;
				hold_req = 1'b1;
				run_episode(30);
			end else begin
				steady = ($urandom_range(0, 5) == 0);
				run_episode($urandom_range(15, 50));
			end
			steady = 1'b0;
			episode++;
		end

		drain_timer();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.awaited_replies.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/podt_pkg.sv
sv/podt_core.sv
sv/periodic_oneshot_deadline_timer.sv
sim/periodic_oneshot_deadline_timer_test.sv
